FILE: design/ctf_pkg.sv
`timescale 1ns / 1ps
package ctf_pkg;

	localparam int CALIB_SAMPLES   = 50;
	localparam int CORDIC_STEPS    = 16;
	localparam int ANGLE_FRAC_BITS = 8;

	localparam int ANGLE_W     = 17;
	localparam int ANGLE_MAX   = 180 << ANGLE_FRAC_BITS;
	localparam int ANGLE_SHIFT = 16 - ANGLE_FRAC_BITS;
	localparam int CORDIC_W    = 44;
	localparam int Z_W         = 26;
	localparam int STEP_W      = $clog2(CORDIC_STEPS);
	localparam int COUNT_W     = $clog2(CALIB_SAMPLES + 1);
	localparam int SUM_W       = ANGLE_W + COUNT_W;

	// The gyro divisor 131e6 shares a factor of 2^6 with the 2^F scale, so the
	// gyro term reduces to (|prod| * 2^(F-6) + bias) / 2046875.
	localparam longint GYRO_DIV   = 131000000;
	localparam int     GYRO_PRE   = 6;
	localparam longint GYRO_DIV_R = GYRO_DIV >> GYRO_PRE;
	localparam longint GYRO_BIAS  = (GYRO_DIV / 2) >> GYRO_PRE;
	localparam int     NUM_W      = 34;
	localparam int     DIV_W      = 21;
	localparam int     QUO_W      = 13;
	localparam int     EST_SHIFT  = NUM_W - DIV_W;
	localparam int     GYRO_SHIFT = NUM_W - EST_SHIFT;
	localparam int     GYRO_RECIP = int'((64'sd1 << NUM_W) / GYRO_DIV_R);
	localparam int     GRECIP_W   = 14;

	localparam int N_W          = 23;
	localparam int BLEND_SHIFT  = 26;
	localparam int BLEND_RECIP  = ((1 << BLEND_SHIFT) + 24) / 25;
	localparam int CALIB_SHIFT  = 28;
	localparam int CALIB_RECIP  = ((1 << CALIB_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
	localparam int RECIP_W      = 24;

	localparam logic [15:0] PERIOD_RESET = 16'd20000;
	localparam logic        REG_PERIOD   = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_CAL,
		ST_BLEND_A,
		ST_BLEND_B,
		ST_DONE
	} ctf_state_t;

	typedef struct packed {
		logic start;
		logic mix;
		logic commit;
	} ctf_lane_ctrl_t;

	// atan(2^-i) in degrees times 65536.
	function automatic logic [21:0] atan_lookup(input logic [4:0] i);
		logic [21:0] v;
		case (i)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234378;
			5'd5:  v = 22'd117303;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/ctf_if.sv
`timescale 1ns / 1ps
interface ctf_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic               start_calibration;

	modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y,
		start_calibration, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y,
		start_calibration, output ready);
endinterface

interface ctf_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] pitch_angle;
	logic signed [16:0] roll_angle;
	logic               calibrating;

	modport source (output valid, pitch_angle, roll_angle, calibrating, input ready);
	modport sink (input valid, pitch_angle, roll_angle, calibrating, output ready);
endinterface

FILE: design/ctf_cordic.sv
`timescale 1ns / 1ps
module ctf_cordic
	import ctf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [ANGLE_W-1:0] y_in,
	input  logic signed [ANGLE_W-1:0] x_in,
	output logic                      done,
	output logic signed [ANGLE_W-1:0] angle
);

	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]      z_q;
	logic [STEP_W-1:0]          step_q;
	logic                       busy_q, rnd_q, done_q, zero_q;
	logic signed [ANGLE_W-1:0]  angle_q;

	logic signed [CORDIC_W-1:0] xe, ye, x0, y0, xs, ys;
	logic signed [Z_W-1:0]      z0, at;
	logic [Z_W-1:0]             zmag, rmag;
	logic [ANGLE_W-1:0]         cmag;

	always_comb begin
		xe = CORDIC_W'(x_in) <<< 24;
		ye = CORDIC_W'(y_in) <<< 24;
		x0 = xe;
		y0 = ye;
		z0 = '0;
		// Move the vector into the right half plane first.
		if (xe < 0) begin
			if (ye >= 0) begin
				x0 = ye;
				y0 = -xe;
				z0 = Z_W'(90 <<< 16);
			end else begin
				x0 = -ye;
				y0 = xe;
				z0 = -Z_W'(90 <<< 16);
			end
		end
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = Z_W'(atan_lookup(5'(step_q)));
		zmag = (z_q < 0) ? Z_W'(-z_q) : Z_W'(z_q);
		rmag = (zmag + Z_W'(1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;
		cmag = (rmag > Z_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : ANGLE_W'(rmag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				rnd_q  <= 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end else if (rnd_q) begin
			rnd_q  <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (x_in == '0) && (y_in == '0);
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
		if (rnd_q) begin
			if (zero_q)
				angle_q <= '0;
			else
				angle_q <= (z_q < 0) ? -$signed(cmag) : $signed(cmag);
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

FILE: design/ctf_lane.sv
`timescale 1ns / 1ps
module ctf_lane
	import ctf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctf_lane_ctrl_t            ctrl,
	input  logic signed [ANGLE_W-1:0] acc_y,
	input  logic signed [ANGLE_W-1:0] acc_x,
	input  logic signed [15:0]        gyro,
	input  logic [15:0]               period,
	input  logic signed [ANGLE_W-1:0] offset,
	output logic                      done,
	output logic signed [ANGLE_W-1:0] acc_angle,
	output logic signed [ANGLE_W-1:0] estimate
);

	logic                      cordic_done;
	logic signed [32:0]        prod_s1;
	logic                      load_q, neg_q;
	logic [3:0]                div_ph_q;
	logic [NUM_W-1:0]          num_q, rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic signed [N_W-1:0]     n_s2;
	logic signed [ANGLE_W-1:0] est_q;

	logic [32:0]               pmag;
	logic [DIV_W+GRECIP_W-1:0] qprod;
	logic [NUM_W-1:0]          qd;
	logic signed [N_W-1:0]     g, eg, n;
	logic [N_W-1:0]            nmag;
	logic [N_W+RECIP_W-1:0]    bprod;
	logic [N_W-1:0]            bq;
	logic [ANGLE_W-1:0]        bclamp;

	ctf_cordic u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctrl.start),
		.y_in  (acc_y),
		.x_in  (acc_x),
		.done  (cordic_done),
		.angle (acc_angle)
	);

	always_comb begin
		pmag   = (prod_s1 < 0) ? 33'(-prod_s1) : 33'(prod_s1);
		qprod  = (DIV_W+GRECIP_W)'(num_q[NUM_W-1:EST_SHIFT]) *
			(DIV_W+GRECIP_W)'(GYRO_RECIP);
		qd     = NUM_W'(quo_q) * NUM_W'(GYRO_DIV_R);
		g      = neg_q ? -N_W'(quo_q) : N_W'(quo_q);
		eg     = N_W'(est_q) + g;
		n      = (eg <<< 4) + (eg <<< 3) + (N_W'(acc_angle) - N_W'(offset));
		nmag   = (n_s2 < 0) ? N_W'(-n_s2) : N_W'(n_s2);
		bprod  = (nmag + N_W'(12)) * (N_W+RECIP_W)'(BLEND_RECIP);
		bq     = N_W'(bprod >> BLEND_SHIFT);
		bclamp = (bq > N_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : ANGLE_W'(bq);
	end

	// Gyro term: |gyro * period| * 2^F / 131e6, rounded. A reciprocal estimate
	// falls short by at most two, so two compare-and-subtract steps finish it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q   <= 1'b0;
			div_ph_q <= '0;
			est_q    <= '0;
		end else begin
			load_q   <= ctrl.start;
			div_ph_q <= {div_ph_q[2:0], load_q};
			if (ctrl.commit)
				est_q <= (n_s2 < 0) ? -$signed(bclamp) : $signed(bclamp);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start)
			prod_s1 <= gyro * $signed({1'b0, period});
		if (load_q) begin
			neg_q <= prod_s1 < 0;
			num_q <= (NUM_W'(pmag) << (ANGLE_FRAC_BITS - GYRO_PRE)) + NUM_W'(GYRO_BIAS);
		end
		if (div_ph_q[0]) begin
			quo_q <= QUO_W'(qprod >> GYRO_SHIFT);
		end else if (div_ph_q[1]) begin
			rem_q <= num_q - qd;
		end else if ((div_ph_q[2] || div_ph_q[3]) && rem_q >= NUM_W'(GYRO_DIV_R)) begin
			quo_q <= quo_q + 1'b1;
			rem_q <= rem_q - NUM_W'(GYRO_DIV_R);
		end
		if (ctrl.mix)
			n_s2 <= n;
	end

	assign done     = cordic_done && !load_q && (div_ph_q == '0);
	assign estimate = est_q;

endmodule

FILE: design/imu_complementary_tilt_filter.sv
`timescale 1ns / 1ps
// Complementary pitch/roll filter. Each sample beat runs two lanes side by side,
// one for pitch and one for roll: a 16-step vectoring CORDIC gives the
// accelerometer angle while a reciprocal multiply with two correction steps
// scales the gyro rate, then the calibration stage updates sums or offsets and
// each lane blends 24/25 of the integrated estimate with 1/25 of the corrected
// accelerometer angle. The delay to the result is set mostly by the CORDIC
// iteration loop. The next sample is taken once the previous one has left the
// lanes, even while its result still waits in the output register; a result
// that is still held there stalls the lanes in their last state. Angles are in
// degrees times 256, clamped to +-180 degrees. The sample period register sits
// at byte address 0.
module imu_complementary_tilt_filter
	import ctf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ctf_in_if.sink      sample,
	ctf_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ctf_state_t state_q, state_d;
	ctf_lane_ctrl_t ctrl;

	logic [15:0]               period_q;
	logic                      calib_q;
	logic [COUNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0]   psum_q, rsum_q;
	logic signed [ANGLE_W-1:0] poff_q, roff_q;
	logic                      out_valid_q, out_cal_q;
	logic signed [ANGLE_W-1:0] out_pitch_q, out_roll_q;

	logic                      accept, load_out, pdone, rdone;
	logic signed [ANGLE_W-1:0] pacc, racc, pest, rest;
	logic [SUM_W-1:0]          pmag, rmag;
	logic [SUM_W+RECIP_W-1:0]  pprod, rprod;
	logic [ANGLE_W-1:0]        pq, rq;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PERIOD) ? {16'b0, period_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			period_q <= PERIOD_RESET;
		else if (psel && penable && pwrite && pready && paddr[2] == REG_PERIOD)
			period_q <= pwdata[15:0];
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;

	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctrl.start = 1'b1;
					state_d    = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				if (pdone && rdone)
					state_d = ST_CAL;
			end
			ST_CAL: state_d = ST_BLEND_A;
			ST_BLEND_A: begin
				ctrl.mix = 1'b1;
				state_d  = ST_BLEND_B;
			end
			ST_BLEND_B: begin
				ctrl.commit = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	ctf_lane u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.acc_y    (ANGLE_W'(sample.accel_y)),
		.acc_x    (ANGLE_W'(sample.accel_z)),
		.gyro     (sample.gyro_x),
		.period   (period_q),
		.offset   (poff_q),
		.done     (pdone),
		.acc_angle(pacc),
		.estimate (pest)
	);

	ctf_lane u_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.acc_y    (-ANGLE_W'(sample.accel_x)),
		.acc_x    (ANGLE_W'(sample.accel_z)),
		.gyro     (sample.gyro_y),
		.period   (period_q),
		.offset   (roff_q),
		.done     (rdone),
		.acc_angle(racc),
		.estimate (rest)
	);

	// Offset = sum / CALIB_SAMPLES, rounded to nearest (halves away from zero), by reciprocal multiply.
	always_comb begin
		pmag  = ((psum_q < 0) ? SUM_W'(-psum_q) : SUM_W'(psum_q)) + SUM_W'(CALIB_SAMPLES / 2);
		rmag  = ((rsum_q < 0) ? SUM_W'(-rsum_q) : SUM_W'(rsum_q)) + SUM_W'(CALIB_SAMPLES / 2);
		pprod = pmag * (SUM_W+RECIP_W)'(CALIB_RECIP);
		rprod = rmag * (SUM_W+RECIP_W)'(CALIB_RECIP);
		pq    = ANGLE_W'(pprod >> CALIB_SHIFT);
		rq    = ANGLE_W'(rprod >> CALIB_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= 1'b0;
			count_q <= '0;
			psum_q  <= '0;
			rsum_q  <= '0;
			poff_q  <= '0;
			roff_q  <= '0;
		end else if (accept && sample.start_calibration) begin
			calib_q <= 1'b1;
			count_q <= '0;
			psum_q  <= '0;
			rsum_q  <= '0;
		end else if (state_q == ST_CAL && calib_q) begin
			if (count_q < COUNT_W'(CALIB_SAMPLES)) begin
				psum_q  <= psum_q + SUM_W'(pacc);
				rsum_q  <= rsum_q + SUM_W'(racc);
				count_q <= count_q + 1'b1;
			end else begin
				poff_q  <= (psum_q < 0) ? -$signed(pq) : $signed(pq);
				roff_q  <= (rsum_q < 0) ? -$signed(rq) : $signed(rq);
				calib_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pitch_q <= pest;
			out_roll_q  <= rest;
			out_cal_q   <= calib_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.pitch_angle = out_pitch_q;
	assign result.roll_angle  = out_roll_q;
	assign result.calibrating = out_cal_q;

endmodule
